>>> rtl/core/lpg_pkg.sv
// Line point generator package: field widths, action and step codes,
// and the packed pixel record shared by the output buffer and top level.
// No dependencies.
package lpg_pkg;

  localparam int FIELD_W        = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_INC  = 2'd1;
  localparam dir_t DIR_DEC  = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] pixel_x;
    logic [FIELD_W-1:0] pixel_y;
    logic [FIELD_W-1:0] pixel_color;
    logic               last_pixel;
  } pixel_t;

endpackage

>>> rtl/core/lpg_in_if.sv
// Input channel of the line point generator: valid/ready plus the
// action and endpoint fields. Depends on lpg_pkg.
interface lpg_in_if;
  import lpg_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [FIELD_W-1:0] start_x;
  logic [FIELD_W-1:0] start_y;
  logic [FIELD_W-1:0] end_x;
  logic [FIELD_W-1:0] end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);

endinterface

>>> rtl/core/lpg_out_if.sv
// Result channel of the line point generator: valid/ready plus the
// pixel fields. Depends on lpg_pkg.
interface lpg_out_if;
  import lpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] pixel_x;
  logic [FIELD_W-1:0] pixel_y;
  logic [FIELD_W-1:0] pixel_color;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);

endinterface

>>> rtl/core/lpg_out_buf.sv
// Two-entry output buffer (result register plus skid register) for pixels.
// Depends on lpg_pkg and lpg_out_if.
module lpg_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_vld,
  input  lpg_pkg::pixel_t push_pix,
  output logic            can_take,
  lpg_out_if.source       out_item
);
  import lpg_pkg::*;

  logic   out_vld_r, out_vld_nxt;
  logic   skid_vld_r, skid_vld_nxt;
  pixel_t out_pix_r, out_pix_nxt;
  pixel_t skid_pix_r, skid_pix_nxt;
  logic   out_fire;

  assign out_fire = out_vld_r && out_item.ready;
  assign can_take = !skid_vld_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_pix_nxt  = out_pix_r;
    skid_pix_nxt = skid_pix_r;
    if (skid_vld_r) begin
      // input is stalled; drain the skid entry once the result is taken
      if (out_fire) begin
        out_pix_nxt  = skid_pix_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (out_vld_r && !out_item.ready) begin
      // result still waiting: park a new pixel in the skid entry
      if (push_vld) begin
        skid_pix_nxt = push_pix;
        skid_vld_nxt = 1'b1;
      end
    end else begin
      out_vld_nxt = push_vld;
      if (push_vld) begin
        out_pix_nxt = push_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_pix_r  <= out_pix_nxt;
    skid_pix_r <= skid_pix_nxt;
  end

  assign out_item.valid       = out_vld_r;
  assign out_item.pixel_x     = out_pix_r.pixel_x;
  assign out_item.pixel_y     = out_pix_r.pixel_y;
  assign out_item.pixel_color = out_pix_r.pixel_color;
  assign out_item.last_pixel  = out_pix_r.last_pixel;

endmodule

>>> rtl/core/line_point_generator.sv
// Line point generator top level: error-accumulating line stepper with a
// pen color register. Depends on lpg_pkg, lpg_in_if, lpg_out_if, lpg_out_buf.
//
//   channel   dir  handshake          payload
//   in_item   in   valid/ready        action, start_x, start_y, end_x, end_y
//   out_item  out  valid/ready        pixel_x, pixel_y, pixel_color, last_pixel
//   cfg_*     in   cfg_we (no wait)   cfg_data -> pen color
//
// One item per clock while in_item.ready is high: in the same cycle, an
// accepted item updates the line state and, unless it is an advance while
// idle, loads its pixel into the result register, or into the skid entry
// while a result is still waiting.
// Reset (rst_n low, synchronous) leaves the block idle with pen color zero.
// A stalled output fills the skid entry; in_item.ready drops only while the
// skid entry is occupied, and rises again the cycle after it drains.
module line_point_generator #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lpg_in_if.sink                      in_item,
  lpg_out_if.source                   out_item,
  input  logic                        cfg_we,
  input  logic [lpg_pkg::FIELD_W-1:0] cfg_data
);
  import lpg_pkg::*;

  localparam int ERR_W = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_W-1:0]      err_t;

  function automatic coord_t step_pos(coord_t pos, dir_t dir);
    coord_t res;
    case (dir)
      DIR_INC: res = pos + coord_t'(1);
      DIR_DEC: res = pos - coord_t'(1);
      default: res = pos;
    endcase
    return res;
  endfunction

  // line state
  coord_t             cur_col_r, cur_col_nxt;
  coord_t             cur_row_r, cur_row_nxt;
  err_t               col_err_r, col_err_nxt;
  err_t               row_err_r, row_err_nxt;
  coord_t             abs_dx_r, abs_dx_nxt;
  coord_t             abs_dy_r, abs_dy_nxt;
  coord_t             major_r, major_nxt;
  dir_t               col_dir_r, col_dir_nxt;
  dir_t               row_dir_r, row_dir_nxt;
  err_t               pix_left_r, pix_left_nxt;
  logic               busy_r, busy_nxt;
  logic [FIELD_W-1:0] pen_color_r;

  logic   in_fire;
  logic   is_start;
  logic   buf_ready;
  logic   res_vld;
  pixel_t res_pix;

  // start decode
  coord_t sx, sy, ex, ey;
  coord_t st_dx, st_dy, st_major;
  dir_t   st_cdir, st_rdir;

  // advance datapath
  err_t   col_sum, row_sum;
  logic   col_step, row_step;
  logic   is_last;

  assign in_fire  = in_item.valid && in_item.ready;
  assign is_start = (in_item.action == ACT_START);
  assign in_item.ready = buf_ready;

  // endpoint bits above the coordinate width are dropped
  assign sx = in_item.start_x[COORD_BITS-1:0];
  assign sy = in_item.start_y[COORD_BITS-1:0];
  assign ex = in_item.end_x[COORD_BITS-1:0];
  assign ey = in_item.end_y[COORD_BITS-1:0];

  always_comb begin
    st_dx    = (ex > sx) ? (ex - sx) : (sx - ex);
    st_dy    = (ey > sy) ? (ey - sy) : (sy - ey);
    st_cdir  = (ex > sx) ? DIR_INC : ((ex == sx) ? DIR_NONE : DIR_DEC);
    st_rdir  = (ey > sy) ? DIR_INC : ((ey == sy) ? DIR_NONE : DIR_DEC);
    st_major = (st_dx > st_dy) ? st_dx : st_dy;
  end

  // each error gains its delta; step the axis when it passes the distance
  assign col_sum  = col_err_r + ERR_W'(abs_dx_r);
  assign row_sum  = row_err_r + ERR_W'(abs_dy_r);
  assign col_step = col_sum > ERR_W'(major_r);
  assign row_step = row_sum > ERR_W'(major_r);
  assign is_last  = (pix_left_r <= err_t'(1));

  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    col_err_nxt  = col_err_r;
    row_err_nxt  = row_err_r;
    abs_dx_nxt   = abs_dx_r;
    abs_dy_nxt   = abs_dy_r;
    major_nxt    = major_r;
    col_dir_nxt  = col_dir_r;
    row_dir_nxt  = row_dir_r;
    pix_left_nxt = pix_left_r;
    busy_nxt     = busy_r;
    res_vld      = 1'b0;
    res_pix      = '{pixel_x:     FIELD_W'(cur_col_r),
                     pixel_y:     FIELD_W'(cur_row_r),
                     pixel_color: pen_color_r,
                     last_pixel:  is_last};
    if (in_fire) begin
      if (is_start) begin
        // load a new line and emit its start point; errors start at zero,
        // and one delta never exceeds the major distance, so the first
        // error update just takes the deltas and no axis steps
        cur_col_nxt  = sx;
        cur_row_nxt  = sy;
        abs_dx_nxt   = st_dx;
        abs_dy_nxt   = st_dy;
        major_nxt    = st_major;
        col_dir_nxt  = st_cdir;
        row_dir_nxt  = st_rdir;
        col_err_nxt  = ERR_W'(st_dx);
        row_err_nxt  = ERR_W'(st_dy);
        pix_left_nxt = ERR_W'(st_major) + err_t'(1);
        busy_nxt     = 1'b1;
        res_vld      = 1'b1;
        res_pix      = '{pixel_x:     FIELD_W'(sx),
                         pixel_y:     FIELD_W'(sy),
                         pixel_color: pen_color_r,
                         last_pixel:  1'b0};
      end else if (busy_r) begin
        // emit the current point, then advance the pen
        res_vld      = 1'b1;
        col_err_nxt  = col_step ? (col_sum - ERR_W'(major_r)) : col_sum;
        row_err_nxt  = row_step ? (row_sum - ERR_W'(major_r)) : row_sum;
        cur_col_nxt  = col_step ? step_pos(cur_col_r, col_dir_r) : cur_col_r;
        cur_row_nxt  = row_step ? step_pos(cur_row_r, row_dir_r) : cur_row_r;
        pix_left_nxt = is_last ? '0 : (pix_left_r - err_t'(1));
        busy_nxt     = !is_last;
      end
      // advance while idle: drop the item, hold the state
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      col_err_r   <= '0;
      row_err_r   <= '0;
      abs_dx_r    <= '0;
      abs_dy_r    <= '0;
      major_r     <= '0;
      col_dir_r   <= DIR_NONE;
      row_dir_r   <= DIR_NONE;
      pix_left_r  <= '0;
      busy_r      <= 1'b0;
      pen_color_r <= '0;
    end else begin
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      col_err_r  <= col_err_nxt;
      row_err_r  <= row_err_nxt;
      abs_dx_r   <= abs_dx_nxt;
      abs_dy_r   <= abs_dy_nxt;
      major_r    <= major_nxt;
      col_dir_r  <= col_dir_nxt;
      row_dir_r  <= row_dir_nxt;
      pix_left_r <= pix_left_nxt;
      busy_r     <= busy_nxt;
      if (cfg_we) begin
        pen_color_r <= cfg_data;
      end
    end
  end

  lpg_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (res_vld),
    .push_pix (res_pix),
    .can_take (buf_ready),
    .out_item (out_item)
  );

  // a line in progress always has pixels left, an idle pen has none
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (pix_left_r != '0))
    else $error("busy flag and pixel count disagree");

  // error terms stay within the major distance after every update
  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (col_err_r <= ERR_W'(major_r)) && (row_err_r <= ERR_W'(major_r)))
    else $error("error term above major distance");

  // the major distance covers both deltas
  a_major: assert property (@(posedge clk) disable iff (!rst_n)
    (abs_dx_r <= major_r) && (abs_dy_r <= major_r))
    else $error("major distance below a delta");

  // an accepted start always leaves out_item.valid high in the next cycle
  a_start_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_start) |=> out_item.valid)
    else $error("start item produced no pixel");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for line_point_generator: drives line start and
// advance items, predicts every pixel and compares it with the result channel.
// Depends on lpg_pkg, lpg_in_if, lpg_out_if and the line_point_generator RTL.
module tb_top;
  import lpg_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_SLACK    = 6;      // idle cycles before a pen write
  localparam int END_SLACK      = 20;     // quiet cycles before the verdict
  localparam int LONG_STALL     = 100;    // receiver hold-off, in cycles
  localparam int TIMEOUT_CYCLES = 200000;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_RARE_STALL} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [FIELD_W-1:0] cfg_data;

  lpg_in_if  in_if();
  lpg_out_if out_if();

  line_point_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Line stepper prediction: mirrors the block's pen position, error terms and
  // pixel count, updated at every edge where an item is accepted.
  // ---------------------------------------------------------------------------
  logic [15:0] pen_x, pen_y;
  logic [16:0] err_x, err_y;
  logic [15:0] dx_abs, dy_abs, span;
  dir_t        col_step, row_step;
  logic [16:0] remaining;
  logic        drawing;
  logic [15:0] pen_color;

  pixel_t expected_pixels[$];

  int errors        = 0;
  int items_sent    = 0;
  int lines_started = 0;
  int pixels_seen   = 0;
  int lines_closed  = 0;
  int pen_writes    = 0;

  // Move one position along an axis, wrapping at the coordinate range.
  function automatic logic [15:0] move_pos(input logic [15:0] pos, input dir_t dir);
    if (dir == DIR_INC) return pos + 16'd1;
    if (dir == DIR_DEC) return pos - 16'd1;
    return pos;
  endfunction

  // Queue the current pixel, then let each error term gain its delta; an axis
  // steps only once its error is strictly greater than the major distance.
  task automatic emit_and_step(input logic last);
    pixel_t p;
    p.pixel_x     = pen_x;
    p.pixel_y     = pen_y;
    p.pixel_color = pen_color;
    p.last_pixel  = last;
    expected_pixels.push_back(p);
    err_x = err_x + {1'b0, dx_abs};
    err_y = err_y + {1'b0, dy_abs};
    if (err_x > {1'b0, span}) begin
      err_x = err_x - {1'b0, span};
      pen_x = move_pos(pen_x, col_step);
    end
    if (err_y > {1'b0, span}) begin
      err_y = err_y - {1'b0, span};
      pen_y = move_pos(pen_y, row_step);
    end
  endtask

  task automatic rasterize_item(input logic act, input logic [15:0] sx, input logic [15:0] sy,
                                input logic [15:0] ex, input logic [15:0] ey);
    logic last;
    if (act == ACT_START) begin
      // A start always wins, even over a line still in progress.
      if (ex > sx) begin
        dx_abs = ex - sx; col_step = DIR_INC;
      end else if (ex == sx) begin
        dx_abs = '0;      col_step = DIR_NONE;
      end else begin
        dx_abs = sx - ex; col_step = DIR_DEC;
      end
      if (ey > sy) begin
        dy_abs = ey - sy; row_step = DIR_INC;
      end else if (ey == sy) begin
        dy_abs = '0;      row_step = DIR_NONE;
      end else begin
        dy_abs = sy - ey; row_step = DIR_DEC;
      end
      span      = (dx_abs > dy_abs) ? dx_abs : dy_abs;
      pen_x     = sx;
      pen_y     = sy;
      err_x     = '0;
      err_y     = '0;
      remaining = {1'b0, span} + 17'd1;
      drawing   = 1'b1;
      emit_and_step(1'b0);
    end else if (drawing) begin
      // The start pixel is emitted twice: once on start, once on first advance.
      last = (remaining <= 17'd1);
      emit_and_step(last);
      remaining = last ? 17'd0 : remaining - 17'd1;
      if (last) drawing = 1'b0;
    end
    // An advance with no line in progress produces nothing.
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Sample both channels at the rising edge. Check the result first, then
  // predict from the accepted item: a result never comes in the same cycle as
  // the item that caused it.
  always @(posedge clk) begin : monitor
    pixel_t want;
    if (!rst_n) begin
      pen_x = '0;  pen_y = '0;  err_x = '0;  err_y = '0;
      dx_abs = '0; dy_abs = '0; span = '0;
      col_step = DIR_NONE; row_step = DIR_NONE;
      remaining = '0; drawing = 1'b0; pen_color = '0;
      expected_pixels.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel (%0d,%0d) color %0h last %0b",
                 out_if.pixel_x, out_if.pixel_y, out_if.pixel_color, out_if.last_pixel);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x",     want.pixel_x,     out_if.pixel_x);
          check_field("pixel_y",     want.pixel_y,     out_if.pixel_y);
          check_field("pixel_color", want.pixel_color, out_if.pixel_color);
          check_field("last_pixel",  {15'd0, want.last_pixel}, {15'd0, out_if.last_pixel});
          pixels_seen++;
          if (want.last_pixel) lines_closed++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        rasterize_item(in_if.action, in_if.start_x, in_if.start_y, in_if.end_x, in_if.end_y);
        if (in_if.action == ACT_START) lines_started++;
      end
      if (cfg_we) pen_color = cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a randomly chosen pattern that changes from segment to
  // segment, some segments fully open. A long hold-off runs on request.
  // ---------------------------------------------------------------------------
  bit long_stall_req = 1'b0;

  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    int       phase;
    mode      = RX_OPEN;
    seg_left  = 0;
    hold_left = 0;
    phase     = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && long_stall_req) begin
        long_stall_req = 1'b0;
        hold_left      = LONG_STALL;
      end
      if (hold_left > 0) begin
        // Hold the output shut so the block fills and drops its input ready.
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(16, 150);
        end
        seg_left--;
        phase++;
        case (mode)
          RX_OPEN:         out_if.ready <= 1'b1;
          RX_COIN:         out_if.ready <= ($urandom_range(0, 1) != 0);
          RX_EVERY_FOURTH: out_if.ready <= (phase % 4) != 0;
          default:         out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: items go out in bursts of random length, with short gaps between.
  // Long bursts give stretches with no idling at all.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_item(input logic act, input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] ex, input logic [15:0] ey);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.start_x <= sx;
    in_if.start_y <= sy;
    in_if.end_x   <= ex;
    in_if.end_y   <= ey;
    // Hold the item until the block takes it.
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Advance items carry random endpoints, which the block must ignore.
  task automatic send_advance();
    send_item(ACT_ADVANCE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  // Pause the sender until every expected pixel is out, then let the block
  // settle, since an ignored advance leaves no result to wait for.
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic set_pen(input logic [15:0] color);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= color;
    @(negedge clk);
    cfg_we   <= 1'b0;
    pen_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pen still at its reset value: advance while idle, then a zero-length line.
  task automatic test_idle_and_zero_length();
    send_item(ACT_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ACT_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(ACT_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // A short line on the coordinate edges; the step after its last pixel wraps.
  // One more advance afterwards must produce nothing.
  task automatic test_edge_line();
    send_item(ACT_START, 16'h0003, 16'hFFFD, 16'h0000, 16'hFFFF);
    repeat (4) send_advance();
    send_advance();
  endtask

  // Full-range lines dropped part way, then a line run to its end.
  task automatic test_restart_mid_line();
    send_item(ACT_START, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    repeat (2) send_advance();
    send_item(ACT_START, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_advance();
    send_item(ACT_START, 16'h8000, 16'h7FFF, 16'h7FFA, 16'h8003);
    repeat (7) send_advance();
  endtask

  // Hold the receiver off while a 61-pixel line is offered back to back.
  task automatic test_backpressure();
    long_stall_req = 1'b1;
    send_item(ACT_START, 16'h1000, 16'h2000, 16'h103C, 16'h1FE7);
    repeat (61) send_advance();
  endtask

  // Mostly complete short lines with random placement; some are cut short by
  // a new start, some are random full-range starts that get dropped, and some
  // completed lines are followed by advances that must be ignored.
  task automatic test_random_lines(input int n_items);
    int sent;
    int sx, sy, dx, dy, dmax, major_len, adv;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(ACT_START, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        adv = $urandom_range(0, 3);
        repeat (adv) send_advance();
        sent += 1 + adv;
      end else begin
        sx   = $urandom_range(0, 65535);
        sy   = $urandom_range(0, 65535);
        dmax = ($urandom_range(0, 9) == 0) ? 40 : 8;
        dx   = $urandom_range(0, dmax);
        dy   = ($urandom_range(0, 9) == 0) ? dx : $urandom_range(0, dmax);
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        // Keep the end point in range by flipping the direction.
        if (sx + dx > 65535 || sx + dx < 0) dx = -dx;
        if (sy + dy > 65535 || sy + dy < 0) dy = -dy;
        major_len = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                             : (dy < 0 ? -dy : dy);
        adv  = ($urandom_range(0, 99) < 15) ? $urandom_range(0, major_len) : major_len + 1;
        send_item(ACT_START, sx[15:0], sy[15:0], 16'(sx + dx), 16'(sy + dy));
        repeat (adv) send_advance();
        sent += 1 + adv;
        if (adv == major_len + 1 && $urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 2)) send_advance();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.action  = ACT_START;
    in_if.start_x = '0;
    in_if.start_y = '0;
    in_if.end_x   = '0;
    in_if.end_y   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_zero_length();
    set_pen(16'hFFFF);
    test_edge_line();
    test_restart_mid_line();
    set_pen(16'h5AA5);
    test_backpressure();
    set_pen(16'($urandom_range(0, 65535)));
    test_random_lines(320);
    set_pen(16'h0000);
    test_random_lines(320);
    set_pen(16'hFFFF);
    test_random_lines(320);

    drain_results();
    repeat (END_SLACK) @(negedge clk);

    $display("Sent %0d items over %0d line starts and %0d pen colors;",
             items_sent, lines_started, pen_writes);
    $display("checked %0d pixels, %0d lines run to their last pixel.",
             pixels_seen, lines_closed);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout: run did not finish in %0d cycles", TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lpg_pkg.sv
rtl/core/lpg_in_if.sv
rtl/core/lpg_out_if.sv
rtl/core/lpg_out_buf.sv
rtl/core/line_point_generator.sv
tb/tb_top.sv
